/* hw/rtl/tsm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_pkg
// shared widths, constants and controller/datapath interface types for the
// two-way sorted merge
// ----------------------------------------------------------------------------
package tsm_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FIFO_DEPTH  = 16;

  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
  localparam int MAX_RESULTS = FIFO_DEPTH + 1;
  localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);

  // stream payload widths, padded to whole bytes
  localparam int S_TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int M_TDATA_W = ((VALUE_WIDTH + 2 + 7) / 8) * 8;

  // side codes
  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic accept;     // take the input transaction: push and end mark
    logic pop;        // pop the selected head into the hold register
    logic shift_out;  // move the hold register to the output register
    logic finish;     // load the final result of the item
    logic hold_used;  // hold register carries an element for the final result
  } tsm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pick_valid;  // a head can be emitted
    logic pick_right;  // the head to emit is on the right side
    logic out_free;    // output register can take a result this cycle
  } tsm_status_t;

endpackage

/* hw/rtl/two_way_sorted_merge.sv */
`timescale 1ns / 1ps
// sequence: an accepted item releases n = 0..17 elements; it is first pushed,
// then each released head is popped in turn, then the item closes with the last result
// items: a new item is taken only after the previous one has closed; heads go through the single head-compare unit
// output stalls pause the emission; the last result may wait while the next item enters
// reset: rst is synchronous, active high; clears counts, pointers, end flags,
// signed_compare and the output valid; fifo contents and payload registers are not cleared
// ----------------------------------------------------------------------------
// two_way_sorted_merge
// streaming merge of two ascending sequences into one ascending stream
// ----------------------------------------------------------------------------
module two_way_sorted_merge
  import tsm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration: signed_compare
  input  logic                 cfg_wen,
  input  logic                 cfg_wdata,
  // input transactions
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // value
  input  logic [1:0]           s_tuser,   // from_right, has_element
  input  logic                 s_tlast,   // ends_sequence
  // result transactions
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // out_value, merge_done, overflow
  output logic [1:0]           m_tuser,   // out_valid, out_source
  output logic                 m_tlast    // run_last
);

  tsm_cmd_t    cmd;
  tsm_status_t st;

  // controller sequences each transaction: accept, then one pop per cycle
  // while a head can go out and the output is not stalled, then the closing result
  tsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath keeps both fifos, the compare, a one-deep hold stage that
  // lets the last element carry run_last, and the output register
  tsm_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .in_from_right  (s_tuser[0]),
    .in_has_element (s_tuser[1]),
    .in_value       (s_tdata[VALUE_WIDTH-1:0]),
    .in_ends        (s_tlast),
    .cmd            (cmd),
    .st             (st),
    .m_tready       (m_tready),
    .m_tvalid       (m_tvalid),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast)
  );

  // a pop only happens when the datapath reports an emittable head
  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> st.pick_valid)
    else $error("pop issued with no emittable head");

  // results enter the output register only when it is free
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift_out || cmd.finish) |-> st.out_free)
    else $error("output register overwritten");

  // a held element is shifted out only together with the next pop
  a_shift_with_pop: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_out |-> cmd.pop)
    else $error("hold register shifted without a pop");

  // taking an item never overlaps with emitting results
  a_accept_exclusive: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !(cmd.pop || cmd.finish))
    else $error("accept overlaps emission");

  // the closing result is presented with run_last set
  a_finish_marks_last: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (m_tvalid && m_tlast))
    else $error("final result missing run_last");

endmodule

/* hw/rtl/tsm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_datapath
// side fifos, head compare, hold register and output register
// ----------------------------------------------------------------------------
module tsm_datapath
  import tsm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic                   cfg_wdata,
  input  logic                   in_from_right,
  input  logic                   in_has_element,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   in_ends,
  input  tsm_cmd_t               cmd,
  output tsm_status_t            st,
  input  logic                   m_tready,
  output logic                   m_tvalid,
  output logic [M_TDATA_W-1:0]   m_tdata,   // out_value, merge_done, overflow
  output logic [1:0]             m_tuser,   // out_valid, out_source
  output logic                   m_tlast    // run_last
);

  logic [VALUE_WIDTH-1:0] left_mem  [FIFO_DEPTH];
  logic [VALUE_WIDTH-1:0] right_mem [FIFO_DEPTH];

  logic [CNT_W-1:0] left_count, right_count;
  logic [PTR_W-1:0] left_rd, right_rd, left_wr, right_wr;
  logic             left_ended, right_ended;
  logic             signed_compare;
  logic             item_ovf;

  logic [VALUE_WIDTH-1:0] hold_value;
  logic                   hold_source;

  logic                   out_vld;
  logic [VALUE_WIDTH-1:0] out_value;
  logic                   out_valid, out_source, out_done, out_ovf, out_last;

  logic [VALUE_WIDTH-1:0] left_head, right_head, left_key, right_key, sign_flip;
  logic left_full, right_full, push_left, push_right, merge_done;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign left_head  = left_mem[left_rd];
  assign right_head = right_mem[right_rd];

  // flipping the sign bit turns a signed order into an unsigned one
  assign sign_flip = {signed_compare, {(VALUE_WIDTH - 1){1'b0}}};
  assign left_key  = left_head ^ sign_flip;
  assign right_key = right_head ^ sign_flip;

  assign left_full  = (left_count == CNT_W'(FIFO_DEPTH));
  assign right_full = (right_count == CNT_W'(FIFO_DEPTH));
  assign push_left  = cmd.accept && in_has_element && (in_from_right == SIDE_LEFT) &&
                      !left_full;
  assign push_right = cmd.accept && in_has_element && (in_from_right == SIDE_RIGHT) &&
                      !right_full;

  assign merge_done = left_ended && right_ended && (left_count == '0) &&
                      (right_count == '0);

  always_comb begin
    st.pick_valid = 1'b0;
    st.pick_right = 1'b0;
    if (left_count != '0 && right_count != '0) begin
      st.pick_valid = 1'b1;
      st.pick_right = !(left_key <= right_key);   // ties go left
    end else if (left_count != '0 && right_ended) begin
      st.pick_valid = 1'b1;
    end else if (right_count != '0 && left_ended) begin
      st.pick_valid = 1'b1;
      st.pick_right = 1'b1;
    end
    st.out_free = !out_vld || m_tready;
  end

  // fifo storage, no reset
  always_ff @(posedge clk) begin
    if (push_left) begin
      left_mem[left_wr] <= in_value;
    end
    if (push_right) begin
      right_mem[right_wr] <= in_value;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      hold_value  <= st.pick_right ? right_head : left_head;
      hold_source <= st.pick_right;
    end
    if (cmd.shift_out) begin
      out_value  <= hold_value;
      out_valid  <= 1'b1;
      out_source <= hold_source;
      out_done   <= 1'b0;
      out_ovf    <= item_ovf;
      out_last   <= 1'b0;
    end else if (cmd.finish) begin
      out_value  <= cmd.hold_used ? hold_value : '0;
      out_valid  <= cmd.hold_used;
      out_source <= cmd.hold_used ? hold_source : SIDE_LEFT;
      out_done   <= merge_done;
      out_ovf    <= item_ovf;
      out_last   <= 1'b1;
    end
    if (cmd.accept) begin
      item_ovf <= in_has_element &&
                  ((in_from_right == SIDE_RIGHT) ? right_full : left_full);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      left_count     <= '0;
      right_count    <= '0;
      left_rd        <= '0;
      right_rd       <= '0;
      left_wr        <= '0;
      right_wr       <= '0;
      left_ended     <= 1'b0;
      right_ended    <= 1'b0;
      signed_compare <= 1'b0;
      out_vld        <= 1'b0;
    end else begin
      if (cfg_wen) begin
        signed_compare <= cfg_wdata;
      end
      if (push_left) begin
        left_count <= left_count + 1'b1;
        left_wr    <= ptr_inc(left_wr);
      end
      if (push_right) begin
        right_count <= right_count + 1'b1;
        right_wr    <= ptr_inc(right_wr);
      end
      if (cmd.accept && in_ends) begin
        if (in_from_right == SIDE_RIGHT) begin
          right_ended <= 1'b1;
        end else begin
          left_ended <= 1'b1;
        end
      end
      if (cmd.pop) begin
        if (st.pick_right) begin
          right_count <= right_count - 1'b1;
          right_rd    <= ptr_inc(right_rd);
        end else begin
          left_count <= left_count - 1'b1;
          left_rd    <= ptr_inc(left_rd);
        end
      end
      if (cmd.finish && merge_done) begin
        left_ended  <= 1'b0;
        right_ended <= 1'b0;
      end
      if (cmd.shift_out || cmd.finish) begin
        out_vld <= 1'b1;
      end else if (m_tready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_comb begin
    m_tdata                  = '0;
    m_tdata[VALUE_WIDTH-1:0] = out_value;
    m_tdata[VALUE_WIDTH]     = out_done;
    m_tdata[VALUE_WIDTH+1]   = out_ovf;
  end

  assign m_tvalid = out_vld;
  assign m_tuser  = {out_source, out_valid};
  assign m_tlast  = out_last;

endmodule

/* hw/rtl/tsm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_ctrl
// per-transaction sequencer: take item, emit heads, close with final result
// ----------------------------------------------------------------------------
module tsm_ctrl
  import tsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  tsm_status_t st,
  output tsm_cmd_t    cmd
);

  typedef enum logic {
    IDLE,
    EMIT
  } state_t;

  state_t           state, state_next;
  logic             hold_valid, hold_valid_next;
  logic [EMIT_W-1:0] emit_cnt, emit_cnt_next;
  logic             can_pop;

  assign s_tready = (state == IDLE);
  assign can_pop  = st.pick_valid && (emit_cnt < EMIT_W'(MAX_RESULTS));

  always_comb begin
    cmd             = '0;
    state_next      = state;
    hold_valid_next = hold_valid;
    emit_cnt_next   = emit_cnt;
    case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.accept      = 1'b1;
          state_next      = EMIT;
          hold_valid_next = 1'b0;
          emit_cnt_next   = '0;
        end
      end
      EMIT: begin
        if (can_pop) begin
          // the held element leaves only once the next one is known
          if (!hold_valid || st.out_free) begin
            cmd.pop         = 1'b1;
            cmd.shift_out   = hold_valid;
            hold_valid_next = 1'b1;
            emit_cnt_next   = emit_cnt + 1'b1;
          end
        end else if (st.out_free) begin
          cmd.finish      = 1'b1;
          cmd.hold_used   = hold_valid;
          hold_valid_next = 1'b0;
          state_next      = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      hold_valid <= 1'b0;
      emit_cnt   <= '0;
    end else begin
      state      <= state_next;
      hold_valid <= hold_valid_next;
      emit_cnt   <= emit_cnt_next;
    end
  end

endmodule
